### rtl/assert_macros.svh
// Assertion macros for the word chunk text normalizer.
// Expects signals clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/wctn_pkg.sv
// Shared types and character constants for the word chunk text normalizer.
// No dependencies.
`timescale 1ns / 1ps

package wctn_pkg;

  localparam logic [3:0] WPC_RESET = 4'd4;

  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;
  localparam logic [7:0] CASE_OFS  = 8'd32;

  typedef struct packed {
    logic [7:0] doc_byte;
    logic       doc_end;
  } doc_item_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       chunk_done;
    logic       chunk_dropped;
    logic       chunk_overflow;
  } res_item_t;

endpackage

### rtl/doc_if.sv
// Input channel: one document byte per item.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface doc_if;
  logic       valid;
  logic       ready;
  logic [7:0] doc_byte;
  logic       doc_end;

  modport source (output valid, output doc_byte, output doc_end, input ready);
  modport sink   (input valid, input doc_byte, input doc_end, output ready);
endinterface

### rtl/res_if.sv
// Result channel: one normalized character and chunk flags per item.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface res_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_out;
  logic       chunk_done;
  logic       chunk_dropped;
  logic       chunk_overflow;

  modport source (output valid, output char_valid, output char_out, output chunk_done,
                  output chunk_dropped, output chunk_overflow, input ready);
  modport sink   (input valid, input char_valid, input char_out, input chunk_done,
                  input chunk_dropped, input chunk_overflow, output ready);
endinterface

### rtl/word_chunk_text_normalizer.sv
// Channel  | Dir | Payload
// doc      | in  | doc_byte[7:0], doc_end
// res      | out | char_valid, char_out[7:0], chunk_done, chunk_dropped, chunk_overflow
// cfg      | in  | cfg_we, cfg_data[3:0] (words per chunk)
//
// One byte per cycle while results are taken; results leave from the result register.
// The input register feeds the step logic, which writes the result register.
// Bytes that produce no result leave no result item.
// Synchronous reset clears all word and chunk state and sets words per chunk to 4.
// A stalled result holds the step; the input register absorbs one further byte.
// Depends on wctn_pkg, doc_if, res_if, wctn_in_reg, wctn_step, wctn_out_reg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module word_chunk_text_normalizer #(
  parameter int CHUNK_CAP = 128
) (
  input  logic       clk,
  input  logic       rst,
  doc_if.sink        doc,
  res_if.source      res,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  logic [3:0]          wpc;
  wctn_pkg::doc_item_t in_item, q_item;
  wctn_pkg::res_item_t step_res, out_item;
  logic                q_valid, adv, res_has;
  logic                res_flagged, char_lower, char_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      wpc <= wctn_pkg::WPC_RESET;
    end else if (cfg_we) begin
      wpc <= cfg_data;
    end
  end

  assign in_item.doc_byte = doc.doc_byte;
  assign in_item.doc_end  = doc.doc_end;
  assign adv = q_valid && (!res.valid || res.ready);

  wctn_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (doc.valid),
    .in_ready (doc.ready),
    .in_item  (in_item),
    .take     (adv),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  wctn_step #(.CHUNK_CAP(CHUNK_CAP)) u_step (
    .clk        (clk),
    .rst        (rst),
    .wpc        (wpc),
    .fire       (adv),
    .item       (q_item),
    .res        (step_res),
    .has_result (res_has)
  );

  wctn_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (adv && res_has),
    .res_in    (step_res),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_item  (out_item)
  );

  assign res.char_valid     = out_item.char_valid;
  assign res.char_out       = out_item.char_out;
  assign res.chunk_done     = out_item.chunk_done;
  assign res.chunk_dropped  = out_item.chunk_dropped;
  assign res.chunk_overflow = out_item.chunk_overflow;

  assign res_flagged = res.char_valid || res.chunk_done || res.chunk_dropped ||
                       res.chunk_overflow;
  assign char_lower  = (res.char_out >= wctn_pkg::CH_LOW_A) &&
                       (res.char_out <= wctn_pkg::CH_LOW_Z);
  assign char_digit  = (res.char_out >= wctn_pkg::CH_DIG_0) &&
                       (res.char_out <= wctn_pkg::CH_DIG_9);

  `CHK_IMPLY(a_res_flagged, res.valid, res_flagged, "result item with no flag set")
  `CHK_IMPLY(a_char_range, res.valid && res.char_valid, char_lower || char_digit, "kept character out of range")
  `CHK_IMPLY(a_char_ovf, res.valid && res.char_valid, !res.chunk_overflow, "kept character flagged as overflow")
  `CHK_NEXT(a_res_load, adv && res_has, res.valid, "result item lost")

endmodule

### rtl/wctn_in_reg.sv
// Input register stage: holds one accepted document byte until the step logic takes it.
// Depends on wctn_pkg.
`timescale 1ns / 1ps

module wctn_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wctn_pkg::doc_item_t in_item,
  input  logic               take,
  output logic               q_valid,
  output wctn_pkg::doc_item_t q_item
);

  logic hold_valid;
  wctn_pkg::doc_item_t hold_item;

  assign in_ready = !hold_valid || take;
  assign q_valid  = hold_valid;
  assign q_item   = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

### rtl/wctn_step.sv
// Word, filter and chunk state with the per-byte update logic.
// Depends on wctn_pkg.
`timescale 1ns / 1ps

module wctn_step #(
  parameter int CHUNK_CAP = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          wpc,
  input  logic                fire,
  input  wctn_pkg::doc_item_t item,
  output wctn_pkg::res_item_t res,
  output logic                has_result
);

  localparam int LEN_W = $clog2(CHUNK_CAP);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CHUNK_CAP - 1);

  logic [3:0]       word_count;
  logic             inside_word;
  logic             angle_pending;
  logic [1:0]       skip_left;
  logic [LEN_W-1:0] chunk_length;
  logic             chunk_started;

  logic [3:0]       word_count_next;
  logic             inside_word_next;
  logic             angle_pending_next;
  logic [1:0]       skip_left_next;
  logic [LEN_W-1:0] chunk_length_next;
  logic             chunk_started_next;

  logic [7:0] b;
  logic       is_space, is_lower, is_digit, is_upper, keep_char;
  logic       examine, fin, reach, done, dropped, valid, ovf;
  logic [4:0] count_inc;
  logic       ang1, started1;
  logic [1:0] skip1;
  logic [LEN_W-1:0] len1;
  logic [7:0] ch;

  always_comb begin
    b        = item.doc_byte;
    is_space = (b == wctn_pkg::CH_SPACE) || (b >= wctn_pkg::CH_TAB && b <= wctn_pkg::CH_CR);
    is_lower = (b >= wctn_pkg::CH_LOW_A) && (b <= wctn_pkg::CH_LOW_Z);
    is_digit = (b >= wctn_pkg::CH_DIG_0) && (b <= wctn_pkg::CH_DIG_9);
    is_upper = (b >= wctn_pkg::CH_UP_A) && (b <= wctn_pkg::CH_UP_Z);
    keep_char = is_lower || is_digit || is_upper;
    ch = is_upper ? (b + wctn_pkg::CASE_OFS) : b;

    examine  = 1'b0;
    ang1     = angle_pending;
    skip1    = skip_left;
    started1 = chunk_started;
    if (is_space) begin
      ang1  = 1'b0;
      skip1 = 2'd0;
    end else begin
      started1 = 1'b1;
      if (skip_left != 2'd0) begin
        skip1 = skip_left - 2'd1;
      end else if (angle_pending) begin
        ang1 = 1'b0;
        if (b == wctn_pkg::CH_B || b == wctn_pkg::CH_SLASH) begin
          skip1 = 2'd1;
        end else begin
          examine = 1'b1;
        end
      end else begin
        examine = 1'b1;
      end
    end
    if (examine && b == wctn_pkg::CH_LT) begin
      ang1 = 1'b1;
    end

    valid = 1'b0;
    ovf   = 1'b0;
    len1  = chunk_length;
    if (examine && keep_char) begin
      if (chunk_length < LEN_MAX) begin
        len1  = chunk_length + LEN_W'(1);
        valid = 1'b1;
      end else begin
        ovf = 1'b1;
      end
    end

    // A word ends either at whitespace or, still open, at document end.
    fin       = is_space ? inside_word : item.doc_end;
    count_inc = {1'b0, word_count} + 5'd1;
    reach     = count_inc >= {1'b0, wpc};
    done      = fin && reach;
    dropped   = item.doc_end && !done && started1;

    word_count_next    = word_count;
    chunk_length_next  = len1;
    chunk_started_next = started1;
    if (done) begin
      word_count_next    = 4'd0;
      chunk_length_next  = '0;
      chunk_started_next = 1'b0;
    end else if (fin) begin
      word_count_next = count_inc[3:0];
    end
    inside_word_next   = !is_space;
    angle_pending_next = ang1;
    skip_left_next     = skip1;
    if (item.doc_end) begin
      word_count_next    = 4'd0;
      inside_word_next   = 1'b0;
      angle_pending_next = 1'b0;
      skip_left_next     = 2'd0;
      chunk_length_next  = '0;
      chunk_started_next = 1'b0;
    end

    res.char_valid     = valid;
    res.char_out       = valid ? ch : 8'd0;
    res.chunk_done     = done;
    res.chunk_dropped  = dropped;
    res.chunk_overflow = ovf;
    has_result         = valid || done || dropped || ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= 4'd0;
      inside_word   <= 1'b0;
      angle_pending <= 1'b0;
      skip_left     <= 2'd0;
      chunk_length  <= '0;
      chunk_started <= 1'b0;
    end else if (fire) begin
      word_count    <= word_count_next;
      inside_word   <= inside_word_next;
      angle_pending <= angle_pending_next;
      skip_left     <= skip_left_next;
      chunk_length  <= chunk_length_next;
      chunk_started <= chunk_started_next;
    end
  end

endmodule

### rtl/wctn_out_reg.sv
// Result register: holds one result item until the downstream side takes it.
// Depends on wctn_pkg.
`timescale 1ns / 1ps

module wctn_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  wctn_pkg::res_item_t res_in,
  output logic                out_valid,
  input  logic                out_ready,
  output wctn_pkg::res_item_t out_item
);

  logic                hold_valid;
  wctn_pkg::res_item_t hold_item;

  assign out_valid = hold_valid;
  assign out_item  = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (out_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_item <= res_in;
    end
  end

endmodule

### verif/tb_word_chunk_text_normalizer.sv
// Testbench for word_chunk_text_normalizer: directed table, then random text in phases.
// Checks every result against directed-table values or an in-bench normalizer predictor.
// Depends on wctn_pkg, doc_if, res_if and the normalizer RTL.
`timescale 1ns / 1ps

module tb_word_chunk_text_normalizer;

  localparam int CHUNK_CAP   = 128;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_GAP  = 6;

  typedef struct {
    logic [7:0]          b;
    logic                e;
    bit                  typed;
    bit                  any;
    wctn_pkg::res_item_t r;
  } dir_row_t;

  typedef struct {
    logic [3:0] wpc;
    int         send_idle;
    int         recv_stall;
    int         items;
    bit         long_words;
  } phase_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_data;

  doc_if doc_ch ();
  res_if res_ch ();

  word_chunk_text_normalizer #(.CHUNK_CAP(CHUNK_CAP)) u_top (
    .clk      (clk),
    .rst      (rst),
    .doc      (doc_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // normalizer state mirrored in the bench
  logic [3:0] cfg_words;
  logic [3:0] word_cnt;
  bit         in_word;
  bit         lt_seen;
  logic [1:0] skip_cnt;
  int         chunk_chars;
  bit         chunk_open;

  wctn_pkg::res_item_t pending_results [$];
  logic [7:0]          text_q [$];
  dir_row_t            directed_rows [25];
  phase_t              phases [8];

  int                  send_idle;
  int                  recv_stall;
  bit                  long_words;
  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  wctn_pkg::res_item_t got_res;
  wctn_pkg::res_item_t want_res;

  always #10 clk = ~clk;

  function automatic bit close_word();
    if (int'(word_cnt) + 1 >= int'(cfg_words)) begin
      word_cnt    = '0;
      chunk_chars = 0;
      chunk_open  = 1'b0;
      return 1'b1;
    end
    word_cnt = word_cnt + 4'd1;
    return 1'b0;
  endfunction

  task normalize_byte(input logic [7:0] b, input logic e, output bit emit,
                      output wctn_pkg::res_item_t r);
    bit         examine;
    bit         keep;
    bit         kept;
    bit         done;
    bit         dropped;
    bit         ovf;
    logic [7:0] ch;
    begin
      examine = 1'b0;
      keep    = 1'b0;
      kept    = 1'b0;
      done    = 1'b0;
      dropped = 1'b0;
      ovf     = 1'b0;
      ch      = '0;
      if (b == wctn_pkg::CH_SPACE || (b >= wctn_pkg::CH_TAB && b <= wctn_pkg::CH_CR)) begin
        if (in_word) done = close_word();
        in_word  = 1'b0;
        lt_seen  = 1'b0;
        skip_cnt = '0;
      end else begin
        in_word    = 1'b1;
        chunk_open = 1'b1;
        if (skip_cnt != 0) begin
          skip_cnt = skip_cnt - 2'd1;
        end else if (lt_seen) begin
          lt_seen = 1'b0;
          if (b == wctn_pkg::CH_B || b == wctn_pkg::CH_SLASH) skip_cnt = 2'd1;
          else examine = 1'b1;
        end else begin
          examine = 1'b1;
        end
      end
      if (examine) begin
        if ((b >= wctn_pkg::CH_LOW_A && b <= wctn_pkg::CH_LOW_Z) ||
            (b >= wctn_pkg::CH_DIG_0 && b <= wctn_pkg::CH_DIG_9)) begin
          ch   = b;
          keep = 1'b1;
        end else if (b >= wctn_pkg::CH_UP_A && b <= wctn_pkg::CH_UP_Z) begin
          ch   = b + wctn_pkg::CASE_OFS;
          keep = 1'b1;
        end else if (b == wctn_pkg::CH_LT) begin
          lt_seen = 1'b1;
        end
        if (keep) begin
          if (chunk_chars < CHUNK_CAP - 1) begin
            chunk_chars++;
            kept = 1'b1;
          end else begin
            ovf = 1'b1;
          end
        end
      end
      if (e) begin
        if (in_word && close_word()) done = 1'b1;
        if (chunk_open) dropped = 1'b1;
        word_cnt    = '0;
        in_word     = 1'b0;
        lt_seen     = 1'b0;
        skip_cnt    = '0;
        chunk_chars = 0;
        chunk_open  = 1'b0;
      end
      emit             = kept | done | dropped | ovf;
      r.char_valid     = kept;
      r.char_out       = kept ? ch : 8'd0;
      r.chunk_done     = done;
      r.chunk_dropped  = dropped;
      r.chunk_overflow = ovf;
    end
  endtask

  // Present one byte, hold until taken, then record what it should produce.
  task send_doc(input logic [7:0] b, input logic e, input bit typed, input bit typed_any,
                input wctn_pkg::res_item_t typed_r);
    bit                  emit;
    wctn_pkg::res_item_t r;
    begin
      while ($urandom_range(99) < send_idle) begin
        doc_ch.valid = 1'b0;
        @(negedge clk);
      end
      doc_ch.valid    = 1'b1;
      doc_ch.doc_byte = b;
      doc_ch.doc_end  = e;
      @(posedge clk);
      while (!doc_ch.ready) @(posedge clk);
      normalize_byte(b, e, emit, r);
      if (typed) begin
        emit = typed_any;
        r    = typed_r;
      end
      if (emit) pending_results.insert(pending_results.size(), r);
      @(negedge clk);
    end
  endtask

  // Next byte of random text: a whitespace run, then one word.
  task next_text_byte(output logic [7:0] b, output logic e);
    int n;
    int k;
    int pick;
    begin
      if (text_q.size() == 0) begin
        n = $urandom_range(2, 1);
        repeat (n) begin
          k = $urandom_range(5);
          text_q.insert(text_q.size(),
                        k == 0 ? wctn_pkg::CH_SPACE : wctn_pkg::CH_TAB + 8'(k - 1));
        end
        n = long_words ? $urandom_range(16, 8) : $urandom_range(7, 1);
        repeat (n) begin
          pick = long_words ? $urandom_range(57) : $urandom_range(99);
          if (pick < 30) begin
            text_q.insert(text_q.size(), wctn_pkg::CH_LOW_A + 8'($urandom_range(25)));
          end else if (pick < 45) begin
            text_q.insert(text_q.size(), wctn_pkg::CH_UP_A + 8'($urandom_range(25)));
          end else if (pick < 58) begin
            text_q.insert(text_q.size(), wctn_pkg::CH_DIG_0 + 8'($urandom_range(9)));
          end else if (pick < 70) begin
            text_q.insert(text_q.size(), wctn_pkg::CH_LT);
            k = $urandom_range(3);
            if (k == 0) text_q.insert(text_q.size(), wctn_pkg::CH_B);
            else if (k == 1) text_q.insert(text_q.size(), wctn_pkg::CH_SLASH);
          end else if (pick < 78) begin
            text_q.insert(text_q.size(),
                          $urandom_range(1) ? wctn_pkg::CH_B : wctn_pkg::CH_SLASH);
          end else begin
            text_q.insert(text_q.size(), 8'($urandom_range(255)));
          end
        end
      end
      b = text_q.pop_front();
      e = $urandom_range(999) < (long_words ? 2 : 25);
    end
  endtask

  // Drop valid and wait until every expected result is out.
  task settle_block;
    begin
      doc_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
      repeat (SETTLE_GAP) @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_res.char_valid     = res_ch.char_valid;
      got_res.char_out       = res_ch.char_out;
      got_res.chunk_done     = res_ch.chunk_done;
      got_res.chunk_dropped  = res_ch.chunk_dropped;
      got_res.chunk_overflow = res_ch.chunk_overflow;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: valid=%0b char=%h done=%0b dropped=%0b ovf=%0b",
                 $time, got_res.char_valid, got_res.char_out, got_res.chunk_done,
                 got_res.chunk_dropped, got_res.chunk_overflow);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res !== want_res) begin
          mismatches++;
          $display("%0t: mismatch expected valid=%0b char=%h done=%0b dropped=%0b ovf=%0b",
                   $time, want_res.char_valid, want_res.char_out, want_res.chunk_done,
                   want_res.chunk_dropped, want_res.chunk_overflow);
          $display("%0t:          actual   valid=%0b char=%h done=%0b dropped=%0b ovf=%0b",
                   $time, got_res.char_valid, got_res.char_out, got_res.chunk_done,
                   got_res.chunk_dropped, got_res.chunk_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (doc_ch.valid && doc_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int         i;
    int         p;
    logic [7:0] b;
    logic       e;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    doc_ch.valid    = 1'b0;
    doc_ch.doc_byte = '0;
    doc_ch.doc_end  = 1'b0;
    send_idle       = 0;
    recv_stall      = 0;
    long_words      = 1'b0;

    cfg_words   = wctn_pkg::WPC_RESET;
    word_cnt    = '0;
    in_word     = 1'b0;
    lt_seen     = 1'b0;
    skip_cnt    = '0;
    chunk_chars = 0;
    chunk_open  = 1'b0;

    directed_rows = '{
      '{wctn_pkg::CH_UP_A,  1'b0, 1'b1, 1'b1, '{1'b1, wctn_pkg::CH_LOW_A, 1'b0, 1'b0, 1'b0}},
      '{wctn_pkg::CH_UP_Z,  1'b0, 1'b1, 1'b1, '{1'b1, wctn_pkg::CH_LOW_Z, 1'b0, 1'b0, 1'b0}},
      '{wctn_pkg::CH_DIG_0, 1'b0, 1'b1, 1'b1, '{1'b1, wctn_pkg::CH_DIG_0, 1'b0, 1'b0, 1'b0}},
      '{wctn_pkg::CH_DIG_9, 1'b0, 1'b1, 1'b1, '{1'b1, wctn_pkg::CH_DIG_9, 1'b0, 1'b0, 1'b0}},
      '{8'hFF,              1'b0, 1'b1, 1'b0, '0},
      '{8'h00,              1'b0, 1'b1, 1'b0, '0},
      '{8'd64,              1'b0, 1'b1, 1'b0, '0},
      '{8'd91,              1'b0, 1'b1, 1'b0, '0},
      '{8'd96,              1'b0, 1'b1, 1'b0, '0},
      '{8'd123,             1'b0, 1'b1, 1'b0, '0},
      '{wctn_pkg::CH_SLASH, 1'b0, 1'b1, 1'b0, '0},
      '{8'd58,              1'b0, 1'b1, 1'b0, '0},
      '{wctn_pkg::CH_LT,    1'b0, 1'b0, 1'b0, '0},
      '{wctn_pkg::CH_B,     1'b0, 1'b0, 1'b0, '0},
      '{wctn_pkg::CH_LT,    1'b0, 1'b0, 1'b0, '0},
      '{wctn_pkg::CH_B,     1'b0, 1'b0, 1'b0, '0},
      '{wctn_pkg::CH_LT,    1'b0, 1'b0, 1'b0, '0},
      '{8'h51,              1'b0, 1'b0, 1'b0, '0},
      '{wctn_pkg::CH_LT,    1'b0, 1'b0, 1'b0, '0},
      '{wctn_pkg::CH_TAB,   1'b0, 1'b0, 1'b0, '0},
      '{8'd8,               1'b0, 1'b1, 1'b0, '0},
      '{8'd14,              1'b0, 1'b1, 1'b0, '0},
      '{wctn_pkg::CH_SPACE, 1'b0, 1'b1, 1'b0, '0},
      '{8'd11,              1'b0, 1'b1, 1'b0, '0},
      '{8'h78,              1'b1, 1'b1, 1'b1, '{1'b1, 8'h78, 1'b0, 1'b1, 1'b0}}
    };

    phases = '{
      '{4'd1,  0,  0,  90,  1'b0},
      '{4'd15, 79, 0,  200, 1'b1},
      '{4'd0,  0,  79, 90,  1'b0},
      '{4'd3,  15, 15, 90,  1'b0},
      '{4'd15, 0,  79, 200, 1'b1},
      '{4'd2,  79, 0,  90,  1'b0},
      '{4'($urandom_range(14, 4)), 15, 15, 90, 1'b0},
      '{4'd1,  0,  0,  70,  1'b0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < 25; i++) begin
      send_doc(directed_rows[i].b, directed_rows[i].e, directed_rows[i].typed,
               directed_rows[i].any, directed_rows[i].r);
    end

    for (p = 0; p < 8; p++) begin
      settle_block();
      cfg_we    = 1'b1;
      cfg_data  = phases[p].wpc;
      cfg_words = phases[p].wpc;
      @(negedge clk);
      cfg_we     = 1'b0;
      send_idle  = phases[p].send_idle;
      recv_stall = phases[p].recv_stall;
      long_words = phases[p].long_words;
      for (i = 0; i < phases[p].items; i++) begin
        next_text_byte(b, e);
        send_doc(b, e, 1'b0, 1'b0, '0);
      end
    end

    settle_block();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
